// ===== rtl/polynomial_least_squares_fit_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the least-squares fit unit
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_LEAST_SQUARES_FIT_UNIT_DEFINES_SVH
`define POLYNOMIAL_LEAST_SQUARES_FIT_UNIT_DEFINES_SVH

// same-cycle implication
`define PLSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsf assertion failed");

// next-cycle implication
`define PLSF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsf assertion failed");

`endif

// ===== rtl/plsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_pkg
// Types, codes and saturating Q32.32 helpers for the least-squares fit unit.
// ----------------------------------------------------------------------------
package plsf_pkg;

  localparam int SUM_W = 40;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SING = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         coef_index;
    logic signed [47:0] coef_value;
    logic [1:0]         status;
    logic               last_coef;
  } out_item_t;

  // request into a shared arithmetic unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } op_req_t;

  typedef struct packed {
    logic         done;
    logic         neg;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        done;
    logic        neg;
    logic        over;
    logic [63:0] quo;
  } div_rsp_t;

  // value plus saturation flag
  typedef struct packed {
    logic [63:0] v;
    logic        sat;
  } sres_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PT_PX, S_PT_PXW, S_PT_ACC, S_PT_PYW, S_PT_NEXT,
    S_SWAP, S_EL_K, S_EL_I, S_EL_DW, S_EL_J, S_EL_MW,
    S_BS_I, S_BS_J, S_BS_MW, S_BS_DW, S_OUT
  } state_t;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic sres_t make_signed(input logic neg, input logic [63:0] mag,
                                        input logic over);
    sres_t r;
    if (neg) begin
      if (over || mag > S64_MIN) r = '{v: S64_MIN, sat: 1'b1};
      else                       r = '{v: ~mag + 64'd1, sat: 1'b0};
    end else begin
      if (over || mag[63]) r = '{v: S64_MAX, sat: 1'b1};
      else                 r = '{v: mag, sat: 1'b0};
    end
    return r;
  endfunction

  function automatic sres_t qmul(input mul_rsp_t m);
    return make_signed(m.neg, m.prod[95:32], |m.prod[127:96]);
  endfunction

  function automatic sres_t sadd(input logic [63:0] a, input logic [63:0] b);
    sres_t       r;
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) r = '{v: a[63] ? S64_MIN : S64_MAX, sat: 1'b1};
    else                                  r = '{v: s, sat: 1'b0};
    return r;
  endfunction

  function automatic sres_t ssub(input logic [63:0] a, input logic [63:0] b);
    sres_t       r;
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) r = '{v: a[63] ? S64_MIN : S64_MAX, sat: 1'b1};
    else                                  r = '{v: s, sat: 1'b0};
    return r;
  endfunction

endpackage

// ===== rtl/polynomial_least_squares_fit_unit.sv =====
`timescale 1ns / 1ps
// Point item: busy while each power and each moment takes its turn on the shared multiplier.
// Solve item: a zero-pivot swap pass over the rows, one divide per pivot row pair and per
// coefficient, one multiply per matrix term; results leave one per cycle, degree+1 items.
// A point past the count limit is dropped in the accept cycle, no busy time.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous active-low reset: sums, count cleared, degree = 2; matrix storage is not reset.
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_unit
// Polynomial least-squares fit via Hankel normal equations and Gaussian
// elimination, sequenced over one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
`include "polynomial_least_squares_fit_unit_defines.svh"

module polynomial_least_squares_fit_unit #(
  parameter int MAX_DEGREE = 3,
  parameter int MAX_POINTS = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plsf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output plsf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);
  import plsf_pkg::*;

  localparam int NDIM = MAX_DEGREE + 1;
  localparam int NPOW = 2 * MAX_DEGREE + 1;
  localparam int RW   = (NDIM > 1) ? $clog2(NDIM) : 1;
  localparam int CW   = $clog2(NDIM + 1);
  localparam int PW   = $clog2(NPOW);

  // registers
  state_t                 state_r, state_nxt;
  logic [1:0]             degree_r;
  logic [CW-1:0]          d_r, n_r;
  logic signed [15:0]     x_r, y_r;
  logic signed [16:0]     p_r;
  logic [PW-1:0]          pi_r;
  logic [16:0]            cnt_r;
  logic [SUM_W-1:0]       power_r  [NPOW];
  logic [SUM_W-1:0]       moment_r [NDIM];
  logic [63:0]            wm_r     [NDIM][NDIM+1];
  logic [63:0]            coef_r   [NDIM];
  logic [CW-1:0]          k_r, i_r, j_r;
  logic [63:0]            m_r, s_r;
  logic                   sat_r, sing_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // shared units
  op_req_t  mul_req, div_req;
  mul_rsp_t mul_rsp;
  div_rsp_t div_rsp;

  plsf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  plsf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // degree in use: 0 acts as 1, above the max clamps
  logic [CW-1:0] d_cur, n_cur;
  always_comb begin
    if (degree_r == 2'd0)                      d_cur = CW'(1);
    else if (32'(degree_r) > MAX_DEGREE)       d_cur = CW'(MAX_DEGREE);
    else                                       d_cur = CW'(degree_r);
    n_cur = d_cur + CW'(1);
  end

  logic accept, pt_full;
  assign accept  = start && (state_r == S_IDLE);
  assign pt_full = (cnt_r >= 17'(MAX_POINTS));

  // matrix taps
  logic [RW-1:0] ir, kr;
  logic [63:0]   a_ik, a_kk, a_kj, a_ij, a_in, a_ii, coef_j;
  always_comb begin
    ir     = i_r[RW-1:0];
    kr     = k_r[RW-1:0];
    a_ik   = wm_r[ir][k_r];
    a_kk   = wm_r[kr][k_r];
    a_kj   = wm_r[kr][j_r];
    a_ij   = wm_r[ir][j_r];
    a_in   = wm_r[ir][n_r];
    a_ii   = wm_r[ir][i_r];
    coef_j = coef_r[j_r[RW-1:0]];
  end

  // truncated Q1.15 product from the multiplier
  logic signed [16:0] tr_val;
  logic [16:0]        tr_mag;
  always_comb begin
    tr_mag = {1'b0, mul_rsp.prod[30:15]};
    tr_val = mul_rsp.neg ? -$signed(tr_mag) : $signed(tr_mag);
  end

  sres_t qm, el_sub, bs_sum, bs_diff, dv;
  always_comb begin
    qm      = qmul(mul_rsp);
    el_sub  = ssub(a_ij, qm.v);
    bs_sum  = sadd(s_r, qm.v);
    bs_diff = ssub(a_in, s_r);
    dv      = make_signed(div_rsp.neg, div_rsp.quo, div_rsp.over);
  end

  // zero-diagonal row search: first other row with both mirror entries nonzero
  logic          swap_hit;
  logic [RW-1:0] swap_row;
  always_comb begin
    swap_hit = 1'b0;
    swap_row = '0;
    for (int r = NDIM - 1; r >= 0; r--) begin
      if (r < int'(n_r) && RW'(r) != ir &&
          wm_r[r][i_r] != 64'd0 && wm_r[ir][CW'(r)] != 64'd0) begin
        swap_hit = 1'b1;
        swap_row = RW'(r);
      end
    end
  end

  logic pi_le_d, pi_last;
  assign pi_le_d = (32'(pi_r) <= 32'(d_r));
  assign pi_last = (32'(pi_r) == 2 * 32'(d_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_SOLVE) state_nxt = S_SWAP;
          else if (!pt_full)            state_nxt = S_PT_ACC;
        end
      end
      S_PT_PX:   state_nxt = S_PT_PXW;
      S_PT_PXW:  if (mul_rsp.done) state_nxt = S_PT_ACC;
      S_PT_ACC:  state_nxt = pi_le_d ? S_PT_PYW : S_PT_NEXT;
      S_PT_PYW:  if (mul_rsp.done) state_nxt = S_PT_NEXT;
      S_PT_NEXT: state_nxt = pi_last ? S_IDLE : S_PT_PX;
      S_SWAP:    if (i_r == n_r - CW'(1)) state_nxt = S_EL_K;
      S_EL_K: begin
        if (k_r == n_r)          state_nxt = S_BS_I;
        else if (a_kk == 64'd0)  state_nxt = S_OUT;
        else                     state_nxt = S_EL_I;
      end
      S_EL_I:    state_nxt = (i_r == n_r) ? S_EL_K : S_EL_DW;
      S_EL_DW:   if (div_rsp.done) state_nxt = S_EL_J;
      S_EL_J:    state_nxt = S_EL_MW;
      S_EL_MW:   if (mul_rsp.done) state_nxt = (j_r == n_r) ? S_EL_I : S_EL_J;
      S_BS_I:    state_nxt = S_BS_J;
      S_BS_J:    state_nxt = (j_r == n_r) ? S_BS_DW : S_BS_MW;
      S_BS_MW:   if (mul_rsp.done) state_nxt = S_BS_J;
      S_BS_DW:   if (div_rsp.done) state_nxt = (i_r == '0) ? S_OUT : S_BS_I;
      S_OUT:     if (i_r == n_r - CW'(1)) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      S_PT_PX: begin
        mul_req = '{start: 1'b1, a: 64'(p_r), b: 64'(x_r)};
      end
      S_PT_ACC: begin
        if (pi_le_d) mul_req = '{start: 1'b1, a: 64'(p_r), b: 64'(y_r)};
      end
      S_EL_I: begin
        if (i_r != n_r) div_req = '{start: 1'b1, a: a_ik, b: a_kk};
      end
      S_EL_J: begin
        mul_req = '{start: 1'b1, a: m_r, b: a_kj};
      end
      S_BS_J: begin
        if (j_r == n_r) div_req = '{start: 1'b1, a: bs_diff.v, b: a_ii};
        else            mul_req = '{start: 1'b1, a: a_ij, b: coef_j};
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // output conversion: Q32.32 -> Q24.24, truncate toward zero, saturate to 48 bits
  logic [63:0]        oc;
  logic signed [55:0] ov;
  logic               osat;
  always_comb begin
    oc   = coef_r[ir];
    ov   = 56'($signed(oc) >>> 8) + 56'(oc[63] && (oc[7:0] != 8'd0));
    osat = !((&ov[55:47]) || !(|ov[55:47]));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      degree_r    <= 2'd2;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < NPOW; q++) power_r[q] <= '0;
      for (int q = 0; q < NDIM; q++) moment_r[q] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_OUT);
      if (cfg_we) degree_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (accept && in_item.cmd == CMD_SOLVE) begin
            cnt_r <= '0;
            for (int q = 0; q < NPOW; q++) power_r[q] <= '0;
            for (int q = 0; q < NDIM; q++) moment_r[q] <= '0;
          end
        end
        S_PT_ACC:  power_r[pi_r] <= power_r[pi_r] + SUM_W'(p_r);
        S_PT_PYW: begin
          if (mul_rsp.done) moment_r[pi_r[RW-1:0]] <= moment_r[pi_r[RW-1:0]] + SUM_W'(tr_val);
        end
        S_PT_NEXT: if (pi_last) cnt_r <= cnt_r + 17'd1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_r    <= in_item.x_value;
          y_r    <= in_item.y_value;
          d_r    <= d_cur;
          n_r    <= n_cur;
          p_r    <= 17'sd32768;
          pi_r   <= '0;
          i_r    <= '0;
          k_r    <= '0;
          sat_r  <= 1'b0;
          sing_r <= 1'b0;
          if (in_item.cmd == CMD_SOLVE) begin
            for (int r = 0; r < NDIM; r++) begin
              for (int c = 0; c <= NDIM; c++) begin
                if (CW'(c) == n_cur)
                  wm_r[r][c] <= {{7{moment_r[r][SUM_W-1]}}, moment_r[r], 17'd0};
                else if (r + c < NPOW)
                  wm_r[r][c] <= {{7{power_r[r+c][SUM_W-1]}}, power_r[r+c], 17'd0};
                else
                  wm_r[r][c] <= 64'd0;
              end
            end
          end
        end
      end
      S_PT_PXW:  if (mul_rsp.done) p_r <= tr_val;
      S_PT_NEXT: pi_r <= pi_r + PW'(1);
      S_SWAP: begin
        if (a_ii == 64'd0 && swap_hit) begin
          for (int c = 0; c <= NDIM; c++) begin
            wm_r[ir][c]       <= wm_r[swap_row][c];
            wm_r[swap_row][c] <= wm_r[ir][c];
          end
        end
        i_r <= (i_r == n_r - CW'(1)) ? '0 : i_r + CW'(1);
      end
      S_EL_K: begin
        if (k_r == n_r) begin
          i_r <= n_r - CW'(1);
        end else if (a_kk == 64'd0) begin
          sing_r <= 1'b1;
          i_r    <= '0;
        end else begin
          i_r <= k_r + CW'(1);
        end
      end
      S_EL_I: if (i_r == n_r) k_r <= k_r + CW'(1);
      S_EL_DW: begin
        if (div_rsp.done) begin
          m_r   <= dv.v;
          sat_r <= sat_r | dv.sat;
          j_r   <= k_r;
        end
      end
      S_EL_MW: begin
        if (mul_rsp.done) begin
          wm_r[ir][j_r] <= el_sub.v;
          sat_r         <= sat_r | qm.sat | el_sub.sat;
          if (j_r == n_r) i_r <= i_r + CW'(1);
          else            j_r <= j_r + CW'(1);
        end
      end
      S_BS_I: begin
        s_r <= 64'd0;
        j_r <= i_r + CW'(1);
      end
      S_BS_J: if (j_r == n_r) sat_r <= sat_r | bs_diff.sat;
      S_BS_MW: begin
        if (mul_rsp.done) begin
          s_r   <= bs_sum.v;
          sat_r <= sat_r | qm.sat | bs_sum.sat;
          j_r   <= j_r + CW'(1);
        end
      end
      S_BS_DW: begin
        if (div_rsp.done) begin
          coef_r[ir] <= dv.v;
          sat_r      <= sat_r | dv.sat;
          if (i_r != '0) i_r <= i_r - CW'(1);
        end
      end
      S_OUT: begin
        out_item_r.coef_index <= 2'(i_r);
        out_item_r.last_coef  <= (i_r == n_r - CW'(1));
        if (sing_r) begin
          out_item_r.coef_value <= '0;
          out_item_r.status     <= STAT_SING;
        end else if (osat) begin
          out_item_r.coef_value <= ov[55] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          out_item_r.status     <= STAT_SAT;
        end else begin
          out_item_r.coef_value <= ov[47:0];
          out_item_r.status     <= sat_r ? STAT_SAT : STAT_OK;
        end
        i_r <= i_r + CW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // only the final coefficient may leave after the sequencer has gone idle
  `PLSF_ASSERT_IMP(a_out_busy, out_valid_r && !out_item_r.last_coef, busy)
  // a point item never produces a result
  `PLSF_ASSERT_NXT(a_pt_silent, accept && in_item.cmd == CMD_POINT, !out_valid_r)
  // the last coefficient closes the burst
  `PLSF_ASSERT_NXT(a_last_ends, out_valid_r && out_item_r.last_coef, !out_valid_r)

endmodule

// ===== rtl/plsf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_mul
// 64x64 sign-magnitude multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module plsf_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  plsf_pkg::op_req_t  req,
  output plsf_pkg::mul_rsp_t rsp
);
  import plsf_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         run_r, done_r;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] pp_shift;

  always_comb begin
    pp       = (cnt_r[1] ? ma_r[63:32] : ma_r[31:0]) * (cnt_r[0] ? mb_r[63:32] : mb_r[31:0]);
    sh       = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    pp_shift = {64'd0, pp} << {sh, 5'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        ma_r  <= mag64(req.a);
        mb_r  <= mag64(req.b);
        neg_r <= req.a[63] ^ req.b[63];
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_r + pp_shift;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, neg: neg_r, prod: acc_r};

endmodule

// ===== rtl/plsf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_div
// Q32.32 restoring divider: |a|*2^32 / |b|, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  plsf_pkg::op_req_t  req,
  output plsf_pkg::div_rsp_t rsp
);
  import plsf_pkg::*;

  logic [127:0] num_r;
  logic [63:0]  den_r, rem_r, quo_r;
  logic         neg_r, over_r, run_r, done_r;
  logic [6:0]   cnt_r;
  logic [63:0]  rs;
  logic         take;

  always_comb begin
    rs   = {rem_r[62:0], num_r[127]};
    take = rem_r[63] || (rs >= den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= {32'd0, mag64(req.a), 32'd0};
        den_r  <= mag64(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        rem_r  <= '0;
        quo_r  <= '0;
        over_r <= 1'b0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        num_r  <= {num_r[126:0], 1'b0};
        rem_r  <= take ? rs - den_r : rs;
        quo_r  <= {quo_r[62:0], take};
        over_r <= over_r | quo_r[63];
        cnt_r  <= cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, neg: neg_r, over: over_r, quo: quo_r};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polynomial least-squares fit unit. Point and
// solve items go in through the start/busy handshake; a fit predictor works
// out the coefficients of every solve and each strobed result is checked
// field by field against the oldest predicted coefficient. The fit degree is
// rewritten between phases, and the sender idles at several rates.
// ----------------------------------------------------------------------------
module tb_top;
  import plsf_pkg::*;

  localparam int MAX_DEG  = 3;
  localparam int MAX_PTS  = 65535;
  localparam int WDOG_MAX = 20000;
  localparam int SETTLE   = 100;

  localparam longint Q64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LIM48   = 64'sh0000_8000_0000_0000;

  // --------------------------------------------------------------------------
  // Fit predictor and store of expected coefficients
  // --------------------------------------------------------------------------
  class fit_scoreboard;
    bit [1:0]  degree_reg;
    longint    pow_sum[2*MAX_DEG+1];
    longint    mom_sum[MAX_DEG+1];
    int        n_points;
    bit        sat_seen;
    out_item_t coef_q[$];
    int        n_errors;

    function new();
      degree_reg = 2'd2;
      clear_sums();
      n_errors = 0;
    endfunction

    function void clear_sums();
      foreach (pow_sum[i]) pow_sum[i] = 0;
      foreach (mom_sum[i]) mom_sum[i] = 0;
      n_points = 0;
    endfunction

    function int fit_degree();
      if (degree_reg == 0) return 1;
      if (degree_reg > MAX_DEG) return MAX_DEG;
      return degree_reg;
    endfunction

    function bit [63:0] abs64(longint v);
      bit [63:0] u;
      u = v;
      return v < 0 ? (~u + 64'd1) : u;
    endfunction

    function longint to_signed(bit neg, bit [63:0] m, bit over);
      if (neg) begin
        if (over || m > 64'h8000_0000_0000_0000) begin
          sat_seen = 1'b1;
          return Q64_MIN;
        end
        return longint'(~m + 64'd1);
      end
      if (over || m[63]) begin
        sat_seen = 1'b1;
        return Q64_MAX;
      end
      return longint'(m);
    endfunction

    // Q1.15 product, truncated toward zero
    function longint mul15(longint a, longint b);
      bit [63:0] m;
      m = (abs64(a) * abs64(b)) >> 15;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint qmul(longint a, longint b);
      bit [127:0] p;
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      return to_signed((a < 0) != (b < 0), p[95:32], |p[127:96]);
    endfunction

    function longint qdiv(longint a, longint b);
      bit [127:0] num, q;
      bit [63:0]  d;
      d = abs64(b);
      if (d == 0) begin
        sat_seen = 1'b1;
        return 0;
      end
      num = {32'd0, abs64(a), 32'd0};
      q   = num / {64'd0, d};
      return to_signed((a < 0) != (b < 0), q[63:0], |q[127:64]);
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
        sat_seen = 1'b1;
        return a < 0 ? Q64_MIN : Q64_MAX;
      end
      return s;
    endfunction

    function longint sat_sub(longint a, longint b);
      longint s;
      s = a - b;
      if ((a < 0) != (b < 0) && (s < 0) != (a < 0)) begin
        sat_seen = 1'b1;
        return a < 0 ? Q64_MIN : Q64_MAX;
      end
      return s;
    endfunction

    // Hankel normal equations, Gaussian elimination, back substitution
    function void solve_fit();
      longint    w[MAX_DEG+1][MAX_DEG+2];
      longint    coef[MAX_DEG+1];
      longint    t, m, s, v;
      int        n;
      bit        ok;
      bit [1:0]  st;
      out_item_t r;
      n = fit_degree() + 1;
      sat_seen = 1'b0;
      ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) w[i][j] = pow_sum[i+j] * 131072;
        w[i][n] = mom_sum[i] * 131072;
        coef[i] = 0;
      end
      // zero diagonal: swap with first row that has both cross terms nonzero
      for (int i = 0; i < n; i++) begin
        if (w[i][i] != 0) continue;
        for (int j = 0; j < n; j++) begin
          if (j == i) continue;
          if (w[j][i] != 0 && w[i][j] != 0) begin
            for (int k = 0; k <= n; k++) begin
              t = w[j][k];
              w[j][k] = w[i][k];
              w[i][k] = t;
            end
            break;
          end
        end
      end
      for (int k = 0; k < n && ok; k++) begin
        if (w[k][k] == 0) begin
          ok = 1'b0;
        end else begin
          for (int i = k + 1; i < n; i++) begin
            m = qdiv(w[i][k], w[k][k]);
            for (int j = k; j <= n; j++) w[i][j] = sat_sub(w[i][j], qmul(m, w[k][j]));
          end
        end
      end
      if (ok) begin
        for (int i = n - 1; i >= 0; i--) begin
          s = 0;
          for (int j = i + 1; j < n; j++) s = sat_add(s, qmul(w[i][j], coef[j]));
          coef[i] = qdiv(sat_sub(w[i][n], s), w[i][i]);
        end
      end
      for (int i = 0; i < n; i++) begin
        v  = 0;
        st = STAT_SING;
        if (ok) begin
          v  = coef[i] / 256;
          st = sat_seen ? STAT_SAT : STAT_OK;
          if (v >= LIM48) begin
            v  = LIM48 - 1;
            st = STAT_SAT;
          end
          if (v < -LIM48) begin
            v  = -LIM48;
            st = STAT_SAT;
          end
        end
        r.coef_index = i[1:0];
        r.coef_value = v[47:0];
        r.status     = st;
        r.last_coef  = (i == n - 1);
        coef_q.push_back(r);
      end
      clear_sums();
    endfunction

    function void note_item(in_item_t it);
      longint p, x, y;
      int     d;
      if (it.cmd != CMD_POINT) begin
        solve_fit();
        return;
      end
      if (n_points >= MAX_PTS) return;
      d = fit_degree();
      x = it.x_value;
      y = it.y_value;
      p = 32768;
      for (int i = 0; i <= 2 * d; i++) begin
        if (i > 0) p = mul15(p, x);
        pow_sum[i] += p;
        if (i <= d) mom_sum[i] += mul15(p, y);
      end
      n_points++;
    endfunction

    function void check_coef(out_item_t got);
      out_item_t exp_c;
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected coefficient %p", $time, got);
        n_errors++;
        return;
      end
      exp_c = coef_q.pop_front();
      if (got.coef_index !== exp_c.coef_index) begin
        $display("%0t: coef_index expected %0d actual %0d",
                 $time, exp_c.coef_index, got.coef_index);
        n_errors++;
      end
      if (got.coef_value !== exp_c.coef_value) begin
        $display("%0t: coef_value expected %0d actual %0d",
                 $time, exp_c.coef_value, got.coef_value);
        n_errors++;
      end
      if (got.status !== exp_c.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_c.status, got.status);
        n_errors++;
      end
      if (got.last_coef !== exp_c.last_coef) begin
        $display("%0t: last_coef expected %0b actual %0b",
                 $time, exp_c.last_coef, got.last_coef);
        n_errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  fit_scoreboard fit_sb = new();
  int  idle_pct;      // chance per cycle that the sender idles
  int  wdog_cnt;

  always #2 clk = ~clk;

  polynomial_least_squares_fit_unit #(
    .MAX_DEGREE(MAX_DEG),
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) fit_sb.check_coef(out_item);
  end

  // watchdog: cycles without an accepted item or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // start stays high on return so back-to-back items need no re-raise
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    fit_sb.note_item(it);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    in_item_t it;
    it.cmd     = CMD_POINT;
    it.x_value = x;
    it.y_value = y;
    send_item(it);
    sender_gap();
  endtask

  // x/y are don't-care on a solve, so randomize them
  task automatic send_solve();
    in_item_t it;
    it.cmd     = CMD_SOLVE;
    it.x_value = 16'($urandom);
    it.y_value = 16'($urandom);
    send_item(it);
    sender_gap();
  endtask

  // drain: wait for all expected coefficients, then let any point in flight finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (fit_sb.coef_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_degree(input logic [1:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    fit_sb.degree_reg = d;
  endtask

  function automatic logic signed [15:0] rand_x();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(255) - 128);     // tiny, powers vanish
      1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one data set, mostly well-formed, sometimes degenerate
  task automatic random_fit(inout int cnt);
    int np;
    logic signed [15:0] x0;
    np = $urandom_range(8);                              // zero points -> singular
    x0 = 16'($urandom);
    for (int i = 0; i < np; i++) begin
      if ($urandom_range(9) == 0) send_point(x0, 16'($urandom));   // repeated abscissa
      else                        send_point(rand_x(), 16'($urandom));
    end
    send_solve();
    cnt += np + 1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] deg_seq[4];
    int pct_seq[4];
    int cnt;

    deg_seq  = '{2'd1, 2'd3, 2'd0, 2'd2};
    pct_seq  = '{0, 81, 10, 81};
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset degree 2: empty solve is singular
    send_solve();
    // field extremes
    send_point(16'sh8000, 16'sh7FFF);
    send_point(16'sh7FFF, 16'sh8000);
    send_point(16'sh0000, 16'sh0000);
    send_point(16'sh4000, 16'shC000);
    send_point(16'shFFFF, 16'sh0001);
    send_solve();
    // all abscissas zero: higher sums vanish, no swap possible -> singular
    send_point(16'sh0000, 16'sh1234);
    send_point(16'sh0000, 16'shEDCB);
    send_solve();
    // degree 1, tiny x: x^2 truncates to zero so the rows get swapped
    write_degree(2'd1);
    send_point(16'sh0001, 16'sh0005);
    send_point(16'sh0002, 16'sh0007);
    send_point(16'sh0003, 16'sh0009);
    send_solve();
    // degree 3 exact cubic-ish and a degree change between points
    write_degree(2'd3);
    send_point(16'shC000, 16'sh1000);
    send_point(16'sh2000, 16'sh3000);
    write_degree(2'd0);
    send_point(16'sh6000, 16'shF000);
    send_point(16'shA000, 16'sh7000);
    send_solve();

    // random phases over all degree settings and idle rates
    for (int ph = 0; ph < 4; ph++) begin
      write_degree(deg_seq[ph]);
      idle_pct = pct_seq[ph];
      cnt = 0;
      while (cnt < 28) random_fit(cnt);
    end

    drain();
    if (fit_sb.n_errors == 0 && fit_sb.coef_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== polynomial_least_squares_fit_unit.f =====
+incdir+rtl
rtl/plsf_pkg.sv
rtl/plsf_mul.sv
rtl/plsf_div.sv
rtl/polynomial_least_squares_fit_unit.sv
tb/sv/tb_top.sv
